### sv/apc_pkg.sv
// shared types and codes for the masked aabb plane-set culling block
// no dependencies
`default_nettype none

package apc_pkg;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_TEST   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic {
    FPU_MUL = 1'b0,
    FPU_ADD = 1'b1
  } fpu_op_t;

  localparam int unsigned MASK_W = 6;
  localparam logic [31:0] FP_QNAN = 32'h7fc0_0000;

endpackage

`default_nettype wire

### sv/apc_fpu.sv
// single-precision multiply or add unit, round to nearest even, subnormals kept
// depends on apc_pkg
`default_nettype none

module apc_fpu
  import apc_pkg::*;
(
  input  fpu_op_t     op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  function automatic logic [5:0] lzc50(input logic [49:0] v);
    logic [5:0] n;
    n = 6'd50;
    for (int i = 0; i < 50; i++) begin
      if (v[i]) n = 6'(49 - i);
    end
    return n;
  endfunction

  // m has its leading one at bit 49, e is the biased exponent for that one
  function automatic logic [31:0] fp_round(input logic s, input logic signed [10:0] e,
                                           input logic [49:0] m);
    logic [49:0] sh;
    logic        st;
    logic [5:0]  amt;
    logic [23:0] man;
    logic        g;
    logic        stk;
    logic [24:0] r;
    logic [10:0] eo;
    logic [31:0] res;
    if (e <= 11'sd0) begin
      amt = (e < -11'sd48) ? 6'd50 : 6'(11'sd1 - e);
      sh  = m >> amt;
      st  = |(m & ~({50{1'b1}} << amt));
    end else begin
      amt = 6'd0;
      sh  = m;
      st  = 1'b0;
    end
    man = sh[49:26];
    g   = sh[25];
    stk = st | (|sh[24:0]);
    r   = {1'b0, man} + 25'(g & (stk | man[0]));
    if (e <= 11'sd0) begin
      res = {s, 7'd0, r[23], r[22:0]};
    end else begin
      eo = e;
      if (r[24]) begin
        eo  = eo + 11'd1;
        res = {s, eo[7:0], r[23:1]};
      end else begin
        res = {s, eo[7:0], r[22:0]};
      end
      if (eo >= 11'd255) res = {s, 8'hff, 23'd0};
    end
    return res;
  endfunction

  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [7:0]  ae, be;
  logic [23:0] am, bm;

  assign ae     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
  assign be     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
  assign am     = {|a[30:23], a[22:0]};
  assign bm     = {|b[30:23], b[22:0]};
  assign a_nan  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
  assign b_nan  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
  assign a_inf  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
  assign b_inf  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
  assign a_zero = (a[30:0] == 31'd0);
  assign b_zero = (b[30:0] == 31'd0);

  // multiply path
  logic [47:0]        prod;
  logic [49:0]        mv;
  logic [5:0]         mlz;
  logic signed [10:0] me;
  logic [31:0]        mul_y;
  logic               ms;

  always_comb begin
    ms   = a[31] ^ b[31];
    prod = am * bm;
    mv   = {prod, 2'b00};
    mlz  = lzc50(mv);
    me   = $signed({3'b000, ae}) + $signed({3'b000, be}) - 11'sd126
           - $signed({5'b00000, mlz});
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      mul_y = FP_QNAN;
    end else if (a_inf || b_inf) begin
      mul_y = {ms, 8'hff, 23'd0};
    end else if (a_zero || b_zero) begin
      mul_y = {ms, 31'd0};
    end else begin
      mul_y = fp_round(ms, me, mv << mlz);
    end
  end

  // add path: x is the larger magnitude
  logic               swap;
  logic [31:0]        xv, wv;
  logic [7:0]         xe, we, d;
  logic [27:0]        xa, wa, ws, sum;
  logic [49:0]        av;
  logic [5:0]         alz;
  logic signed [10:0] aexp;
  logic [31:0]        add_y;

  always_comb begin
    swap = a[30:0] < b[30:0];
    xv   = swap ? b : a;
    wv   = swap ? a : b;
    xe   = swap ? be : ae;
    we   = swap ? ae : be;
    xa   = {1'b0, (swap ? bm : am), 3'b000};
    wa   = {1'b0, (swap ? am : bm), 3'b000};
    d    = xe - we;
    if (d > 8'd27) begin
      ws = 28'(|wa);
    end else begin
      ws = (wa >> d) | 28'(|(wa & ~({28{1'b1}} << d)));
    end
    sum  = (xv[31] == wv[31]) ? xa + ws : xa - ws;
    av   = {sum, 22'd0};
    alz  = lzc50(av);
    aexp = $signed({3'b000, xe}) + 11'sd1 - $signed({5'b00000, alz});
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
      add_y = FP_QNAN;
    end else if (a_inf || b_inf) begin
      add_y = a_inf ? a : b;
    end else if (sum == 28'd0) begin
      add_y = 32'd0;
    end else begin
      add_y = fp_round(xv[31], aexp, av << alz);
    end
  end

  assign y = (op == FPU_MUL) ? mul_y : add_y;

endmodule

`default_nettype wire

### sv/aabb_plane_set_cull_masked.sv
// masked aabb culling against a stored plane set, one shared fp unit
// test item: a skipped plane costs only a scan; an active plane that passes takes a scan,
// two 6-step distances on the shared multiply/add unit and two checks; a failing one ends the item
// after its near distance and check; one item at a time; the result waits in an output register
// clear and append are done on acceptance; rst clears the plane count and the handshake state;
// the plane store is not cleared; depends on apc_pkg, apc_fpu
`default_nettype none

module aabb_plane_set_cull_masked
  import apc_pkg::*;
#(
  parameter int unsigned MAX_PLANES = 6
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // normal_x, normal_y, normal_z, plane_offset, min_x, min_y, min_z,
  // max_x, max_y, max_z, mask_in, zero pad
  input  wire logic [327:0] s_tdata,
  // func
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // hit, mask_out, zero pad
  output logic [7:0]        m_tdata
);

  localparam int unsigned CNT_W = $clog2(MAX_PLANES + 1);
  localparam int unsigned IDX_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int unsigned POS_W = (IDX_W > 3) ? IDX_W : 3;
  localparam int unsigned CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_RUN, ST_CHECK, ST_OUT
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   total;
  logic [POS_W-1:0]   pos;
  logic [2:0]         step;
  logic               far;
  logic               hit;
  logic [MASK_W-1:0]  mask;
  logic [31:0]        bmin [3];
  logic [31:0]        bmax [3];
  logic [31:0]        prod [3];
  logic [31:0]        acc;

  logic [31:0] nx_mem [MAX_PLANES];
  logic [31:0] ny_mem [MAX_PLANES];
  logic [31:0] nz_mem [MAX_PLANES];
  logic [31:0] c_mem  [MAX_PLANES];

  logic             accept;
  func_t            func;
  logic [IDX_W-1:0] ridx;
  logic [31:0]      pn [3];
  logic [31:0]      pc;
  logic             in_range;
  logic             bit_on;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign func     = func_t'(s_tuser);
  assign ridx     = pos[IDX_W-1:0];
  assign pn[0]    = nx_mem[ridx];
  assign pn[1]    = ny_mem[ridx];
  assign pn[2]    = nz_mem[ridx];
  assign pc       = c_mem[ridx];
  assign in_range = (CMP_W'(pos) < CMP_W'(total)) && (pos < POS_W'(MASK_W));
  assign bit_on   = mask[pos[2:0]];

  // operand select for the shared unit
  fpu_op_t     op;
  logic [31:0] opa, opb, fy;
  logic [1:0]  ax;
  logic        use_max;

  always_comb begin
    ax      = step[1:0];
    use_max = 1'b0;
    opa     = acc;
    opb     = prod[2];
    op      = FPU_ADD;
    unique case (step)
      3'd0, 3'd1, 3'd2: begin
        // near corner takes max where the normal is negative, far the other way
        use_max = pn[ax][31] ^ far;
        op      = FPU_MUL;
        opa     = pn[ax];
        opb     = use_max ? bmax[ax] : bmin[ax];
      end
      3'd3: begin
        opa = prod[0];
        opb = prod[1];
      end
      3'd4: begin
        opb = prod[2];
      end
      3'd5: begin
        opb = {~pc[31], pc[30:0]};
      end
      default: begin
        opb = prod[2];
      end
    endcase
  end

  apc_fpu u_fpu (
    .op (op),
    .a  (opa),
    .b  (opb),
    .y  (fy)
  );

  logic acc_nan, acc_lt0, acc_le0;
  assign acc_nan = (acc[30:23] == 8'hff) && (acc[22:0] != 23'd0);
  assign acc_lt0 = !acc_nan && acc[31] && (acc[30:0] != 31'd0);
  assign acc_le0 = !acc_nan && (acc[31] || (acc[30:0] == 31'd0));

  always_ff @(posedge clk) begin
    if (accept && (func == FUNC_APPEND) && (total < CNT_W'(MAX_PLANES))) begin
      nx_mem[total[IDX_W-1:0]] <= s_tdata[31:0];
      ny_mem[total[IDX_W-1:0]] <= s_tdata[63:32];
      nz_mem[total[IDX_W-1:0]] <= s_tdata[95:64];
      c_mem[total[IDX_W-1:0]]  <= s_tdata[127:96];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bmin[0] <= s_tdata[159:128];
      bmin[1] <= s_tdata[191:160];
      bmin[2] <= s_tdata[223:192];
      bmax[0] <= s_tdata[255:224];
      bmax[1] <= s_tdata[287:256];
      bmax[2] <= s_tdata[319:288];
    end
    if (state == ST_RUN) begin
      if (step < 3'd3) begin
        prod[step[1:0]] <= fy;
      end else begin
        acc <= fy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      total    <= '0;
      pos      <= '0;
      step     <= '0;
      far      <= 1'b0;
      hit      <= 1'b0;
      mask     <= '0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_OUT)) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (func)
              FUNC_CLEAR: total <= '0;
              FUNC_APPEND: begin
                if (total < CNT_W'(MAX_PLANES)) total <= total + CNT_W'(1);
              end
              FUNC_TEST: begin
                mask  <= s_tdata[325:320];
                hit   <= 1'b1;
                pos   <= '0;
                state <= ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (!in_range) begin
            state <= ST_OUT;
          end else if (!bit_on) begin
            pos <= pos + POS_W'(1);
          end else begin
            far   <= 1'b0;
            step  <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (step == 3'd5) begin
            state <= ST_CHECK;
          end else begin
            step <= step + 3'd1;
          end
        end
        ST_CHECK: begin
          step <= '0;
          if (!far) begin
            if (!acc_lt0) begin
              hit   <= 1'b0;
              state <= ST_OUT;
            end else begin
              far   <= 1'b1;
              state <= ST_RUN;
            end
          end else begin
            if (acc_le0) mask[pos[2:0]] <= 1'b0;
            pos   <= pos + POS_W'(1);
            state <= ST_SCAN;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, mask, hit};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CNT_W'(MAX_PLANES))
    else $error("plane count above capacity");

  a_run_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> in_range)
    else $error("plane walk beyond stored planes");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && m_tvalid && !m_tready) |=> (state == ST_OUT))
    else $error("result dropped while output busy");

endmodule

`default_nettype wire
